// ----- src/ptm_pkg.sv -----
// shared types, constants and register codes for the pan temperature trend monitor
package ptm_pkg;

  localparam int WINDOW          = 8;
  localparam int TICKS_PER_EPOCH = 50;
  localparam int TICK_W          = 6;
  localparam int IDX_W           = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CFG_IDX_W       = 8;

  typedef logic [7:0]        temp_t;
  typedef logic signed [7:0] slope_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam slope_t STEEP_SLOPE   = 8'sd15;
  localparam slope_t FLAT_SLOPE    = 8'sd1;
  localparam slope_t RELEASE_SLOPE = -8'sd7;
  localparam temp_t  OVER_MARGIN   = 8'd5;
  localparam temp_t  EPOCH_MAX     = 8'hff;
  localparam temp_t  TEMP_MAX      = 8'hff;
  localparam temp_t  TEMP_MIN      = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_MID_TEMP          = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_START_EPOCH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEEP_COUNT_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_READ_EPOCH    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_READ_EPOCH   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COOLING_DROP  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TEMP          = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_DEBOUNCE     = 8'd7;

  localparam temp_t RST_MID_TEMP          = 8'd128;
  localparam temp_t RST_SLOPE_START_EPOCH = 8'd10;
  localparam temp_t RST_STEEP_COUNT_LIMIT = 8'd12;
  localparam temp_t RST_HOT_READ_EPOCH    = 8'd20;
  localparam temp_t RST_COLD_READ_EPOCH   = 8'd30;
  localparam temp_t RST_MIN_COOLING_DROP  = 8'd10;
  localparam temp_t RST_OFF_TEMP          = 8'd200;
  localparam temp_t RST_OVER_DEBOUNCE     = 8'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } scan_ctrl_t;

  typedef struct packed {
    logic   done;
    slope_t slope;
  } scan_stat_t;

endpackage

// ----- src/pan_temperature_trend_monitor.sv -----
// top level of the pan temperature trend monitor
//
// one input transfer per 10 ms tick carries heat_enable and pan_temp; every
// accepted transfer produces exactly one output transfer with protect_mode,
// force_stop and slope as they stand after that tick.
// handshake: a transfer happens when valid is high and stall is low.
// in_stall is high from the accepting edge until the result is placed in the
// output register; the output register holds one result, so a new tick can be
// accepted while the previous result still waits behind out_stall.
// a disabled tick or a tick inside an epoch passes from acceptance through
// the done state into the output register; a tick that closes an epoch runs
// the window scan, one sample per cycle through the shared compare unit, and
// passes through the scan state and the done state to the output register.
// while the output register holds a result and out_stall is high, a finished
// result waits in the sequencer and no new tick is taken until the output register frees up.
// the configuration port always accepts; unknown indexes are ignored. write it
// only while the block is idle.
// reset clears the monitor state and loads the default thresholds; the output data fields are not reset.
module pan_temperature_trend_monitor
  import ptm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 heat_enable,
  input  temp_t                pan_temp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 protect_mode,
  output logic                 force_stop,
  output slope_t               slope,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  temp_t                cfg_data
);

  state_t state;
  state_t state_next;

  temp_t mid_temp;
  temp_t slope_start_epoch;
  temp_t steep_count_limit;
  temp_t hot_read_epoch;
  temp_t cold_read_epoch;
  temp_t min_cooling_drop;
  temp_t off_temp;
  temp_t over_debounce_limit;

  logic [TICK_W-1:0] tick_divider;
  logic [TICK_W-1:0] tick_divider_next;
  temp_t             epoch_count;
  temp_t             epoch_count_next;
  temp_t             sample_window [WINDOW];
  logic              mode_flag;
  logic              mode_flag_next;
  logic              stop_flag;
  logic              stop_flag_next;
  slope_t            slope_value;
  slope_t            slope_value_next;
  temp_t             steep_count;
  temp_t             steep_count_next;
  temp_t             hot_sample;
  temp_t             hot_sample_next;
  temp_t             cold_sample;
  temp_t             cold_sample_next;
  temp_t             over_count;
  temp_t             over_count_next;

  logic accept;
  logic epoch_tick;
  logic shift_window;
  logic clear_window;
  logic out_load;

  logic [TICK_W-1:0] tick_inc;
  temp_t             steep_inc;
  temp_t             over_inc;

  scan_ctrl_t scan_ctrl;
  scan_stat_t scan_stat;
  idx_t       scan_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tick_inc  = tick_divider + 1'b1;
  assign epoch_tick = heat_enable && (tick_inc >= TICK_W'(TICKS_PER_EPOCH));
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  ptm_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (scan_ctrl),
    .sample (sample_window[scan_idx]),
    .idx    (scan_idx),
    .stat   (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_temp            <= RST_MID_TEMP;
      slope_start_epoch   <= RST_SLOPE_START_EPOCH;
      steep_count_limit   <= RST_STEEP_COUNT_LIMIT;
      hot_read_epoch      <= RST_HOT_READ_EPOCH;
      cold_read_epoch     <= RST_COLD_READ_EPOCH;
      min_cooling_drop    <= RST_MIN_COOLING_DROP;
      off_temp            <= RST_OFF_TEMP;
      over_debounce_limit <= RST_OVER_DEBOUNCE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MID_TEMP:          mid_temp            <= cfg_data;
        CFG_SLOPE_START_EPOCH: slope_start_epoch   <= cfg_data;
        CFG_STEEP_COUNT_LIMIT: steep_count_limit   <= cfg_data;
        CFG_HOT_READ_EPOCH:    hot_read_epoch      <= cfg_data;
        CFG_COLD_READ_EPOCH:   cold_read_epoch     <= cfg_data;
        CFG_MIN_COOLING_DROP:  min_cooling_drop    <= cfg_data;
        CFG_OFF_TEMP:          off_temp            <= cfg_data;
        CFG_OVER_DEBOUNCE:     over_debounce_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and per-tick state update
  always_comb begin
    state_next        = state;
    tick_divider_next = tick_divider;
    epoch_count_next  = epoch_count;
    mode_flag_next    = mode_flag;
    stop_flag_next    = stop_flag;
    slope_value_next  = slope_value;
    steep_count_next  = steep_count;
    hot_sample_next   = hot_sample;
    cold_sample_next  = cold_sample;
    over_count_next   = over_count;
    shift_window      = 1'b0;
    clear_window      = 1'b0;
    scan_ctrl.start   = 1'b0;
    steep_inc         = steep_count + 1'b1;
    over_inc          = over_count + 1'b1;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!heat_enable) begin
            clear_window      = 1'b1;
            tick_divider_next = '0;
            epoch_count_next  = '0;
            steep_count_next  = '0;
            mode_flag_next    = 1'b0;
            stop_flag_next    = 1'b0;
            slope_value_next  = '0;
            hot_sample_next   = '0;
            cold_sample_next  = '0;
            state_next        = ST_DONE;
          end else if (!epoch_tick) begin
            tick_divider_next = tick_inc;
            state_next        = ST_DONE;
          end else begin
            tick_divider_next = '0;
            if (epoch_count < EPOCH_MAX) begin
              epoch_count_next = epoch_count + 1'b1;
            end
            stop_flag_next = 1'b0;
            if (!mode_flag) begin
              // steep slope test on the previous slope
              if (pan_temp > mid_temp && epoch_count_next >= slope_start_epoch) begin
                if (slope_value >= STEEP_SLOPE) begin
                  if (steep_inc >= steep_count_limit) begin
                    steep_count_next = '0;
                    mode_flag_next   = 1'b1;
                  end else begin
                    steep_count_next = steep_inc;
                  end
                end else if (slope_value <= FLAT_SLOPE) begin
                  steep_count_next = '0;
                end
              end
              // cooling check window
              if (epoch_count_next >= hot_read_epoch &&
                  epoch_count_next <= cold_read_epoch) begin
                stop_flag_next = 1'b1;
              end
              if (epoch_count_next == hot_read_epoch) begin
                hot_sample_next = pan_temp;
              end
              if (epoch_count_next == cold_read_epoch) begin
                cold_sample_next = pan_temp;
                if (hot_sample_next > pan_temp &&
                    (hot_sample_next - pan_temp) >= min_cooling_drop) begin
                  mode_flag_next = 1'b1;
                end
              end
              // over-temperature debounce
              if (({1'b0, pan_temp} + {1'b0, OVER_MARGIN}) < {1'b0, off_temp}) begin
                over_count_next = '0;
              end else if (pan_temp > off_temp) begin
                if (over_inc > over_debounce_limit) begin
                  over_count_next = '0;
                  mode_flag_next  = 1'b1;
                end else begin
                  over_count_next = over_inc;
                end
              end else begin
                over_count_next = '0;
              end
            end
            shift_window    = 1'b1;
            scan_ctrl.start = 1'b1;
            state_next      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          slope_value_next = scan_stat.slope;
          if (mode_flag && scan_stat.slope <= RELEASE_SLOPE) begin
            mode_flag_next = 1'b0;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_divider <= '0;
      epoch_count  <= '0;
      mode_flag    <= 1'b0;
      stop_flag    <= 1'b0;
      slope_value  <= '0;
      steep_count  <= '0;
      hot_sample   <= '0;
      cold_sample  <= '0;
      over_count   <= '0;
    end else begin
      state        <= state_next;
      tick_divider <= tick_divider_next;
      epoch_count  <= epoch_count_next;
      mode_flag    <= mode_flag_next;
      stop_flag    <= stop_flag_next;
      slope_value  <= slope_value_next;
      steep_count  <= steep_count_next;
      hot_sample   <= hot_sample_next;
      cold_sample  <= cold_sample_next;
      over_count   <= over_count_next;
    end
  end

  // sample history, oldest first
  always_ff @(posedge clk) begin
    if (rst || clear_window) begin
      for (int i = 0; i < WINDOW; i++) begin
        sample_window[i] <= '0;
      end
    end else if (shift_window) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        sample_window[i] <= sample_window[i+1];
      end
      sample_window[WINDOW-1] <= pan_temp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      protect_mode <= mode_flag;
      force_stop   <= stop_flag;
      slope        <= slope_value;
    end
  end

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after a transfer");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output transfer raised outside the done state");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> state == ST_SCAN)
    else $error("scan finished while the sequencer was not waiting");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_divider < TICK_W'(TICKS_PER_EPOCH))
    else $error("tick divider out of range");

endmodule

// ----- src/ptm_scan.sv -----
// iterative min/max scan over the sample window and saturated signed slope
module ptm_scan
  import ptm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scan_ctrl_t ctrl,
  input  temp_t      sample,
  output idx_t       idx,
  output scan_stat_t stat
);

  localparam idx_t LAST_IDX = IDX_W'(WINDOW - 1);

  logic  active;
  logic  done;
  temp_t mn;
  temp_t mx;
  idx_t  mn_at;
  idx_t  mx_at;

  logic signed [9:0] span;
  logic signed [9:0] signed_span;
  slope_t            slope_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      idx    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        if (idx == LAST_IDX) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // running extremes, earliest minimum and latest maximum
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mn    <= TEMP_MAX;
      mx    <= TEMP_MIN;
      mn_at <= '0;
      mx_at <= '0;
    end else if (active) begin
      if (mn > sample) begin
        mn    <= sample;
        mn_at <= idx;
      end
      if (mx <= sample) begin
        mx    <= sample;
        mx_at <= idx;
      end
    end
  end

  always_comb begin
    span        = $signed({2'b00, mx}) - $signed({2'b00, mn});
    signed_span = (mn_at < mx_at) ? span : -span;
    if (signed_span > 10'sd127) begin
      slope_sat = 8'sd127;
    end else if (signed_span < -10'sd128) begin
      slope_sat = -8'sd128;
    end else begin
      slope_sat = signed_span[7:0];
    end
  end

  assign stat.done  = done;
  assign stat.slope = slope_sat;

endmodule
